// File: hw/rtl/cagrid_pkg.sv
package cagrid_pkg;

    // Default grid dimensions: inner area plus a one-cell frame.
    localparam int unsigned INNER_SIZE_DEF = 8;
    localparam int unsigned FULL_SIZE_DEF  = 10;

    // Request kinds.
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_STEP  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // One request transfer.
    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] row;
        logic [3:0] col;
        logic       cell_in;
    } req_t;

    // One result transfer.
    typedef struct packed {
        logic       cell_out;
        logic [1:0] done_kind;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic clear_step;
        logic sweep_step;
        logic access;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_pos;
    } dp_sts_t;

endpackage

// File: hw/rtl/cagrid_ctrl.sv
module cagrid_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          kind,
    input  cagrid_pkg::dp_sts_t sts,
    output cagrid_pkg::ctl_cmd_t cmd,
    output logic                busy,
    output logic                done
);
    import cagrid_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_SWEEP,
        ST_FLUSH,
        ST_RESP
    } state_t;

    state_t state_reg;
    logic   done_reg;

    // State register and the registered result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            // The strobe is high in the last busy cycle of an access or a sweep.
            done_reg <= (state_reg == ST_ACCESS) || (state_reg == ST_FLUSH);
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (sts.last_pos)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (kind == KIND_WRITE || kind == KIND_READ)
                        begin
                            state_reg <= ST_ACCESS;
                        end
                        else if (kind == KIND_STEP)
                        begin
                            state_reg <= ST_SWEEP;
                        end
                    end
                end
                ST_ACCESS:
                begin
                    state_reg <= ST_RESP;
                end
                ST_SWEEP:
                begin
                    if (sts.last_pos)
                    begin
                        state_reg <= ST_FLUSH;
                    end
                end
                ST_FLUSH:
                begin
                    state_reg <= ST_RESP;
                end
                ST_RESP:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Command decode from the current state.
    always_comb
    begin
        cmd.load_req   = (state_reg == ST_IDLE) && start;
        cmd.clear_step = (state_reg == ST_CLEAR);
        cmd.sweep_step = (state_reg == ST_SWEEP);
        cmd.access     = (state_reg == ST_ACCESS);
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    // The result strobe lasts exactly one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // A result only follows a single access or the end of a sweep.
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> ($past(state_reg) == ST_ACCESS || $past(state_reg) == ST_FLUSH))
        else $error("result strobe without a finished request");

    // The last sweep position always leads into the flush cycle.
    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP && sts.last_pos) |=> (state_reg == ST_FLUSH))
        else $error("sweep did not end after its last position");

endmodule

// File: hw/rtl/cagrid_dp.sv
module cagrid_dp #(
    parameter int unsigned INNER_SIZE = cagrid_pkg::INNER_SIZE_DEF,
    parameter int unsigned FULL_SIZE  = cagrid_pkg::FULL_SIZE_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cagrid_pkg::ctl_cmd_t cmd,
    input  cagrid_pkg::req_t     request,
    output cagrid_pkg::dp_sts_t  sts,
    output cagrid_pkg::rsp_t     result
);
    import cagrid_pkg::*;

    localparam int unsigned DEPTH = FULL_SIZE * FULL_SIZE;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(FULL_SIZE);
    localparam int unsigned LIVE  = (INNER_SIZE < FULL_SIZE - 2) ? INNER_SIZE : FULL_SIZE - 2;
    // Shift line spans two full rows plus three cells of the raster stream.
    localparam int unsigned SRL   = 2 * FULL_SIZE + 3;

    logic [DEPTH-1:0] mem;
    logic [SRL-1:0]   sr_reg;

    req_t          req_reg;
    logic [AW-1:0] pos_addr_reg;
    logic [CW-1:0] pos_r_reg;
    logic [CW-1:0] pos_c_reg;
    logic          win_valid_reg;
    logic [AW-1:0] win_addr_reg;
    logic [CW-1:0] win_r_reg;
    logic [CW-1:0] win_c_reg;

    logic          last_pos;
    logic          addr_ok;
    logic [AW-1:0] req_addr;
    logic [AW-1:0] center_addr;
    logic [3:0]    nbr_count;
    logic          center_inner;
    logic          sweep_we;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic          shift_en;

    // Latch the request on its transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= request;
        end
    end

    assign addr_ok  = (32'(req_reg.row) < FULL_SIZE) && (32'(req_reg.col) < FULL_SIZE);
    assign req_addr = AW'(32'(req_reg.row) * FULL_SIZE + 32'(req_reg.col));

    // Raster position counter, shared by the clearing pass and the sweep.
    assign last_pos = (pos_r_reg == CW'(FULL_SIZE - 1)) && (pos_c_reg == CW'(FULL_SIZE - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_addr_reg <= '0;
            pos_r_reg    <= '0;
            pos_c_reg    <= '0;
        end
        else if (cmd.clear_step || cmd.sweep_step)
        begin
            if (last_pos)
            begin
                pos_addr_reg <= '0;
                pos_r_reg    <= '0;
                pos_c_reg    <= '0;
            end
            else
            begin
                pos_addr_reg <= pos_addr_reg + AW'(1);
                if (pos_c_reg == CW'(FULL_SIZE - 1))
                begin
                    pos_c_reg <= '0;
                    pos_r_reg <= pos_r_reg + CW'(1);
                end
                else
                begin
                    pos_c_reg <= pos_c_reg + CW'(1);
                end
            end
        end
    end

    // Position of the newest cell in the shift line.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
        end
        else
        begin
            win_valid_reg <= cmd.sweep_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sweep_step)
        begin
            win_addr_reg <= pos_addr_reg;
            win_r_reg    <= pos_r_reg;
            win_c_reg    <= pos_c_reg;
        end
    end

    // The window is centered one row and one column behind the newest cell.
    assign center_addr  = win_addr_reg - AW'(FULL_SIZE + 1);
    assign center_inner = (win_r_reg >= CW'(2)) && (win_c_reg >= CW'(2))
                       && (win_r_reg <= CW'(LIVE + 1)) && (win_c_reg <= CW'(LIVE + 1));

    // Neighbor count from the fixed taps of the shift line.
    assign nbr_count = 4'(sr_reg[0]) + 4'(sr_reg[1]) + 4'(sr_reg[2])
                     + 4'(sr_reg[FULL_SIZE]) + 4'(sr_reg[FULL_SIZE + 2])
                     + 4'(sr_reg[2 * FULL_SIZE]) + 4'(sr_reg[2 * FULL_SIZE + 1])
                     + 4'(sr_reg[2 * FULL_SIZE + 2]);

    assign sweep_we = win_valid_reg && center_inner
                   && (nbr_count == 4'd2 || nbr_count == 4'd0 || nbr_count == 4'd4);

    // Write port selection.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pos_addr_reg;
        mem_wdata = 1'b0;
        priority if (cmd.clear_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.access)
        begin
            mem_we    = (req_reg.req_type == KIND_WRITE) && addr_ok;
            mem_waddr = req_addr;
            mem_wdata = req_reg.cell_in;
        end
        else
        begin
            mem_we    = sweep_we;
            mem_waddr = center_addr;
            mem_wdata = (nbr_count == 4'd2);
        end
    end

    assign mem_raddr = cmd.access ? req_addr : pos_addr_reg;
    assign shift_en  = cmd.access || cmd.sweep_step;

    // Grid memory; its read data lands in the head of the shift line.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (shift_en)
        begin
            sr_reg <= {sr_reg[SRL-2:0], mem[mem_raddr]};
        end
    end

    assign sts.last_pos     = last_pos;
    assign result.cell_out  = (req_reg.req_type == KIND_READ) && addr_ok && sr_reg[0];
    assign result.done_kind = req_reg.req_type;

    // A window write never lands on the cell being read in the same cycle.
    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (sweep_we && cmd.sweep_step) |-> (center_addr != pos_addr_reg))
        else $error("sweep write hits the current read address");

    // The window is only live in the cycle after a sweep read.
    a_win_follows: assert property (@(posedge clk) disable iff (!rst_n)
        win_valid_reg |-> $past(cmd.sweep_step))
        else $error("window valid without a preceding sweep read");

    // Sweep and clearing pass never overlap.
    a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> (!win_valid_reg && !cmd.sweep_step && !cmd.access))
        else $error("clearing pass overlaps other grid traffic");

endmodule

// File: hw/rtl/cellular_automaton_grid_step.sv
// Single-cell write or read: the request transfer moves the sequencer to ST_ACCESS,
// the result strobe comes in ST_RESP, and the block is then ready for the next request.
// Generation step: one cell per cycle through the grid memory read and write ports,
// then ST_FLUSH writes the last window and the result strobe comes in ST_RESP.
// After reset a clearing pass over all FULL_SIZE*FULL_SIZE cells holds busy high.
// Results are shown for one cycle only; the receiver cannot stall them.
module cellular_automaton_grid_step #(
    parameter int unsigned INNER_SIZE = cagrid_pkg::INNER_SIZE_DEF,
    parameter int unsigned FULL_SIZE  = cagrid_pkg::FULL_SIZE_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cagrid_pkg::req_t request,
    output logic             done,
    output cagrid_pkg::rsp_t result
);
    import cagrid_pkg::*;

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    // Sequencer for clearing, single accesses and generation sweeps.
    cagrid_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (request.req_type),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Grid memory, window shift line and update logic.
    cagrid_dp #(
        .INNER_SIZE (INNER_SIZE),
        .FULL_SIZE  (FULL_SIZE)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .sts     (sts),
        .result  (result)
    );

endmodule

// File: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cagrid_pkg::*;

    // Grid geometry as built by the default parameters.
    localparam int FULL = FULL_SIZE_DEF;
    localparam int INNER = INNER_SIZE_DEF;
    localparam int LIVE = (INNER < FULL - 2) ? INNER : FULL - 2;

    // The one request code the block answers with nothing.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int RANDOM_REQUESTS = 1100;
    localparam int QUIET_FIRST = 400;
    localparam int QUIET_LAST = 600;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = FULL * FULL + 10;
    localparam int PRINT_LIMIT = 50;

    // One row of the directed table.
    typedef struct {
        req_t req;
        bit   typed;
        rsp_t want;
    } vector_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t request = '0;
    logic done;
    rsp_t result;

    bit cells [FULL][FULL];
    rsp_t pending_rsp [$];
    vector_t vectors [$];
    int errors = 0;
    int stall_cycles = 0;

    cellular_automaton_grid_step DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Print one line per mismatch, up to a limit, and count every one.
    task automatic report_mismatch(input string what, input logic [1:0] got,
                                   input logic [1:0] want);
        if (errors < PRINT_LIMIT)
        begin
            $display("%0t: %s: got %b, expected %b", $time, what, got, want);
        end
        errors++;
    endtask

    // One generation: all neighbor counts are taken from the old grid first.
    task automatic run_generation();
        int counts [FULL][FULL];
        for (int r = 1; r <= LIVE; r++)
        begin
            for (int c = 1; c <= LIVE; c++)
            begin
                counts[r][c] = 0;
                for (int dr = -1; dr <= 1; dr++)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        if (dr != 0 || dc != 0)
                        begin
                            counts[r][c] += int'(cells[r + dr][c + dc]);
                        end
                    end
                end
            end
        end
        for (int r = 1; r <= LIVE; r++)
        begin
            for (int c = 1; c <= LIVE; c++)
            begin
                if (counts[r][c] == 2)
                begin
                    cells[r][c] = 1'b1;
                end
                else if (counts[r][c] == 0 || counts[r][c] == 4)
                begin
                    cells[r][c] = 1'b0;
                end
            end
        end
    endtask

    // Apply one request to the grid copy and work out the answer it gives.
    task automatic grid_request(input req_t req, output bit answers, output rsp_t rsp);
        bit on_grid;
        on_grid = (req.row < FULL) && (req.col < FULL);
        answers = 1'b1;
        rsp = '0;
        rsp.done_kind = req.req_type;
        case (req.req_type)
            KIND_WRITE:
            begin
                if (on_grid)
                begin
                    cells[req.row][req.col] = req.cell_in;
                end
            end
            KIND_STEP:
            begin
                run_generation();
            end
            KIND_READ:
            begin
                if (on_grid)
                begin
                    rsp.cell_out = cells[req.row][req.col];
                end
            end
            default:
            begin
                answers = 1'b0;
            end
        endcase
    endtask

    function automatic req_t make_req(input logic [1:0] kind, input logic [3:0] row,
                                      input logic [3:0] col, input logic value);
        req_t req;
        req.req_type = kind;
        req.row = row;
        req.col = col;
        req.cell_in = value;
        return req;
    endfunction

    function automatic void add_vector(input logic [1:0] kind, input logic [3:0] row,
                                       input logic [3:0] col, input logic value,
                                       input bit typed, input logic want_cell);
        vector_t v;
        v.req = make_req(kind, row, col, value);
        v.typed = typed;
        v.want.cell_out = want_cell;
        v.want.done_kind = kind;
        vectors.push_back(v);
    endfunction

    // Random request: mostly on the grid, now and then outside it.
    function automatic req_t random_req();
        req_t req;
        int pick;
        pick = $urandom_range(99);
        if (pick < 4)
        begin
            req.req_type = KIND_UNUSED;
        end
        else if (pick < 18)
        begin
            req.req_type = KIND_STEP;
        end
        else if (pick < 60)
        begin
            req.req_type = KIND_WRITE;
        end
        else
        begin
            req.req_type = KIND_READ;
        end
        if ($urandom_range(9) == 0)
        begin
            req.row = 4'($urandom_range(15));
            req.col = 4'($urandom_range(15));
        end
        else
        begin
            req.row = 4'($urandom_range(FULL - 1));
            req.col = 4'($urandom_range(FULL - 1));
        end
        req.cell_in = 1'($urandom_range(1));
        return req;
    endfunction

    // Drop start for a random gap, in about 27 of a hundred requests.
    task automatic random_gap(input bit allowed);
        int gap;
        if (allowed && $urandom_range(99) < 27)
        begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the request until the block takes it, then record what it should answer.
    task automatic transfer_request(input req_t req, input bit typed, input rsp_t want);
        bit answers;
        rsp_t rsp;
        start <= 1'b1;
        request <= req;
        do @(posedge clk); while (busy !== 1'b0);
        grid_request(req, answers, rsp);
        if (answers)
        begin
            pending_rsp.push_back(typed ? want : rsp);
        end
    endtask

    // Compare every result strobe with the oldest pending answer.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (pending_rsp.size() == 0)
                begin
                    report_mismatch("result with no request pending", result.done_kind,
                                    2'bxx);
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (result.cell_out !== want.cell_out)
                    begin
                        report_mismatch("cell_out", {1'b0, result.cell_out},
                                        {1'b0, want.cell_out});
                    end
                    if (result.done_kind !== want.done_kind)
                    begin
                        report_mismatch("done_kind", result.done_kind, want.done_kind);
                    end
                end
            end
            else if (done !== 1'b0)
            begin
                report_mismatch("done not known", {1'b0, done}, 2'b00);
            end
        end
    end

    // Stop the run when neither a request nor a result has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        req_t req;
        int sent;

        // Directed table: reads after reset, frame corners, addresses off the grid,
        // the unused code, a cell born from two neighbors and one cleared by four.
        add_vector(KIND_READ, 4'd0, 4'd0, 1'b0, 1, 1'b0);
        add_vector(KIND_READ, 4'd9, 4'd9, 1'b1, 1, 1'b0);
        add_vector(KIND_READ, 4'd15, 4'd15, 1'b1, 1, 1'b0);
        add_vector(KIND_WRITE, 4'd0, 4'd0, 1'b1, 1, 1'b0);
        add_vector(KIND_READ, 4'd0, 4'd0, 1'b0, 1, 1'b1);
        add_vector(KIND_WRITE, 4'd9, 4'd9, 1'b1, 1, 1'b0);
        add_vector(KIND_READ, 4'd9, 4'd9, 1'b0, 1, 1'b1);
        add_vector(KIND_WRITE, 4'd15, 4'd15, 1'b1, 1, 1'b0);
        add_vector(KIND_WRITE, 4'd10, 4'd3, 1'b1, 1, 1'b0);
        add_vector(KIND_READ, 4'd10, 4'd3, 1'b0, 1, 1'b0);
        add_vector(KIND_UNUSED, 4'd15, 4'd15, 1'b1, 1, 1'b0);
        add_vector(KIND_WRITE, 4'd1, 4'd2, 1'b1, 1, 1'b0);
        add_vector(KIND_WRITE, 4'd3, 4'd3, 1'b1, 1, 1'b0);
        add_vector(KIND_WRITE, 4'd5, 4'd5, 1'b1, 1, 1'b0);
        add_vector(KIND_WRITE, 4'd4, 4'd4, 1'b1, 1, 1'b0);
        add_vector(KIND_WRITE, 4'd4, 4'd6, 1'b1, 1, 1'b0);
        add_vector(KIND_WRITE, 4'd6, 4'd4, 1'b1, 1, 1'b0);
        add_vector(KIND_WRITE, 4'd6, 4'd6, 1'b1, 1, 1'b0);
        add_vector(KIND_STEP, 4'd15, 4'd0, 1'b1, 1, 1'b0);
        add_vector(KIND_READ, 4'd1, 4'd1, 1'b0, 0, 1'b0);
        add_vector(KIND_READ, 4'd2, 4'd2, 1'b0, 0, 1'b0);
        add_vector(KIND_READ, 4'd5, 4'd5, 1'b0, 0, 1'b0);
        add_vector(KIND_READ, 4'd8, 4'd8, 1'b0, 0, 1'b0);
        add_vector(KIND_READ, 4'd9, 4'd9, 1'b0, 1, 1'b1);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
        begin
            random_gap(1'b1);
            transfer_request(vectors[i].req, vectors[i].typed, vectors[i].want);
        end

        // Random requests, with a quiet stretch where start never drops.
        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            req = random_req();
            random_gap(!(sent >= QUIET_FIRST && sent < QUIET_LAST));
            transfer_request(req, 1'b0, '0);
            if (req.req_type != KIND_UNUSED)
            begin
                sent++;
            end
        end
        start <= 1'b0;

        // Let the last answers arrive, then watch for stray strobes.
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending_rsp.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/cagrid_pkg.sv
hw/rtl/cagrid_ctrl.sv
hw/rtl/cagrid_dp.sv
hw/rtl/cellular_automaton_grid_step.sv
sim/testbench.sv
